>>> hdl/esi_pkg.sv
// Shared types and constants for the escape sequence interpreter.
package esi_pkg;

  // Most beats a single input item can cause (short \U literal plus the next byte).
  localparam int unsigned MaxBeats   = 10;
  localparam int unsigned IdxW       = $clog2(MaxBeats);
  localparam int unsigned LenW       = $clog2(MaxBeats + 1);
  localparam int unsigned QueueDepth = 2;

  typedef logic [MaxBeats-1:0][7:0] byte_list_t;

  // One classified item: the bytes to send, in order, and how to tag the last beat.
  typedef struct packed {
    byte_list_t      bytes;
    logic [LenW-1:0] len;
    logic            has_byte;
    logic            done;
    logic            stopped;
  } cmd_t;

endpackage

>>> hdl/esi_front.sv
// Front end: accepts characters, tracks escape state and builds byte lists.
module esi_front import esi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       end_marker_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o
);

  typedef enum logic [5:0] {
    ModePlain = 6'b000001,
    ModeEsc   = 6'b000010,
    ModeOct   = 6'b000100,
    ModeHex   = 6'b001000,
    ModeUni   = 6'b010000,
    ModeStop  = 6'b100000
  } mode_e;

  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharA      = 8'h61;
  localparam logic [7:0] CharB      = 8'h62;
  localparam logic [7:0] CharC      = 8'h63;
  localparam logic [7:0] CharE      = 8'h65;
  localparam logic [7:0] CharEUp    = 8'h45;
  localparam logic [7:0] CharF      = 8'h66;
  localparam logic [7:0] CharN      = 8'h6E;
  localparam logic [7:0] CharR      = 8'h72;
  localparam logic [7:0] CharT      = 8'h74;
  localparam logic [7:0] CharV      = 8'h76;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharX      = 8'h78;
  localparam logic [7:0] CharULow   = 8'h75;
  localparam logic [7:0] CharUUp    = 8'h55;

  localparam logic [7:0] CtlBel = 8'h07;
  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlEsc = 8'h1B;
  localparam logic [7:0] CtlFf  = 8'h0C;
  localparam logic [7:0] CtlLf  = 8'h0A;
  localparam logic [7:0] CtlCr  = 8'h0D;
  localparam logic [7:0] CtlTab = 8'h09;
  localparam logic [7:0] CtlVt  = 8'h0B;

  localparam logic [31:0] CpMax      = 32'h0010_FFFF;
  localparam logic [31:0] SurrLo     = 32'h0000_D800;
  localparam logic [31:0] SurrHi     = 32'h0000_DFFF;
  localparam logic [7:0]  Utf8Lead2  = 8'hC0;
  localparam logic [7:0]  Utf8Lead3  = 8'hE0;
  localparam logic [7:0]  Utf8Lead4  = 8'hF0;
  localparam logic [7:0]  Utf8Cont   = 8'h80;

  typedef struct packed {
    byte_list_t      bytes;
    logic [LenW-1:0] len;
  } seq_t;

  function automatic byte_list_t lit_list(logic lng, logic [7:0][7:0] digs);
    byte_list_t l;
    l    = '0;
    l[0] = CharBslash;
    l[1] = lng ? CharUUp : CharULow;
    for (int i = 0; i < 8; i++) begin
      l[i+2] = digs[i];
    end
    return l;
  endfunction

  // UTF-8 of a code point, or the literal form for out-of-range and surrogates.
  function automatic seq_t utf8_seq(logic [31:0] cp, byte_list_t lit, logic [LenW-1:0] lit_len);
    seq_t s;
    s.bytes = '0;
    s.len   = '0;
    if (cp > CpMax || (cp >= SurrLo && cp <= SurrHi)) begin
      s.bytes = lit;
      s.len   = lit_len;
    end else if (cp <= 32'h7F) begin
      s.bytes[0] = cp[7:0];
      s.len      = LenW'(1);
    end else if (cp <= 32'h7FF) begin
      s.bytes[0] = Utf8Lead2 | {3'b000, cp[10:6]};
      s.bytes[1] = Utf8Cont | {2'b00, cp[5:0]};
      s.len      = LenW'(2);
    end else if (cp <= 32'hFFFF) begin
      s.bytes[0] = Utf8Lead3 | {4'b0000, cp[15:12]};
      s.bytes[1] = Utf8Cont | {2'b00, cp[11:6]};
      s.bytes[2] = Utf8Cont | {2'b00, cp[5:0]};
      s.len      = LenW'(3);
    end else begin
      s.bytes[0] = Utf8Lead4 | {5'b00000, cp[20:18]};
      s.bytes[1] = Utf8Cont | {2'b00, cp[17:12]};
      s.bytes[2] = Utf8Cont | {2'b00, cp[11:6]};
      s.bytes[3] = Utf8Cont | {2'b00, cp[5:0]};
      s.len      = LenW'(4);
    end
    return s;
  endfunction

  mode_e            mode_q, mode_d;
  logic [31:0]      acc_q, acc_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             long_q, long_d;
  logic             en_q;
  logic [7:0][7:0]  dig_q;
  logic [7:0][7:0]  dig_w;

  logic             accept;
  logic             dig_we;
  logic             hex_ok;
  logic [3:0]       hex_val;
  logic             oct_ok;
  logic [3:0]       cnt_inc;
  logic [7:0]       acc_oct;
  logic [7:0]       acc_hex;
  logic [31:0]      acc_uni;
  byte_list_t       lit;
  logic [LenW-1:0]  lit_len;
  seq_t             uni_seq;
  byte_list_t       pre;
  logic [LenW-1:0]  n_pre;
  logic             tail;
  logic             do_plain;
  logic             has_byte;
  logic             stopped;
  logic [7:0]       c;

  assign c          = char_in_i;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    hex_ok  = 1'b0;
    hex_val = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_ok  = 1'b1;
      hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_ok  = 1'b1;
      hex_val = c[3:0] + 4'd9;
    end
  end

  assign oct_ok  = (c >= 8'h30) && (c <= 8'h37);
  assign cnt_inc = cnt_q + 4'd1;
  assign acc_oct = {acc_q[4:0], c[2:0]};
  assign acc_hex = {acc_q[3:0], hex_val};
  assign acc_uni = {acc_q[27:0], hex_val};

  // The digit being gathered is included; positions past the count are never sent.
  always_comb begin
    dig_w             = dig_q;
    dig_w[cnt_q[2:0]] = c;
  end

  assign lit     = lit_list(long_q, dig_w);
  assign lit_len = LenW'(cnt_q) + LenW'(2);
  assign uni_seq = utf8_seq(acc_uni, lit, LenW'(cnt_inc) + LenW'(2));

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    long_d   = long_q;
    dig_we   = 1'b0;
    pre      = '0;
    n_pre    = '0;
    tail     = 1'b0;
    do_plain = 1'b0;
    has_byte = 1'b1;
    stopped  = 1'b0;

    if (!end_marker_i) begin
      case (mode_q)
        ModePlain: begin
          do_plain = 1'b1;
        end
        ModeEsc: begin
          mode_d = ModePlain;
          acc_d  = '0;
          cnt_d  = '0;
          long_d = 1'b0;
          n_pre  = LenW'(1);
          case (c)
            CharBslash:     pre[0] = CharBslash;
            CharA:          pre[0] = CtlBel;
            CharB:          pre[0] = CtlBs;
            CharE, CharEUp: pre[0] = CtlEsc;
            CharF:          pre[0] = CtlFf;
            CharN:          pre[0] = CtlLf;
            CharR:          pre[0] = CtlCr;
            CharT:          pre[0] = CtlTab;
            CharV:          pre[0] = CtlVt;
            CharC: begin
              mode_d = ModeStop;
              n_pre  = '0;
            end
            CharZero: begin
              mode_d = ModeOct;
              n_pre  = '0;
            end
            CharX: begin
              mode_d = ModeHex;
              n_pre  = '0;
            end
            CharULow: begin
              mode_d = ModeUni;
              n_pre  = '0;
            end
            CharUUp: begin
              mode_d = ModeUni;
              long_d = 1'b1;
              n_pre  = '0;
            end
            default: begin
              // unknown escape goes out as backslash plus the character
              pre[0] = CharBslash;
              tail   = 1'b1;
            end
          endcase
        end
        ModeOct: begin
          if (oct_ok) begin
            acc_d = {24'h0, acc_oct};
            cnt_d = cnt_inc;
            if (cnt_inc >= 4'd3) begin
              pre[0] = acc_oct;
              n_pre  = LenW'(1);
              mode_d = ModePlain;
              acc_d  = '0;
              cnt_d  = '0;
            end
          end else begin
            pre[0]   = acc_q[7:0];
            n_pre    = LenW'(1);
            mode_d   = ModePlain;
            acc_d    = '0;
            cnt_d    = '0;
            do_plain = 1'b1;
          end
        end
        ModeHex: begin
          if (hex_ok) begin
            acc_d = {24'h0, acc_hex};
            cnt_d = cnt_inc;
            if (cnt_inc >= 4'd2) begin
              pre[0] = acc_hex;
              n_pre  = LenW'(1);
              mode_d = ModePlain;
              acc_d  = '0;
              cnt_d  = '0;
            end
          end else begin
            if (cnt_q == 4'd0) begin
              pre[0] = CharBslash;
              pre[1] = CharX;
              n_pre  = LenW'(2);
            end else begin
              pre[0] = acc_q[7:0];
              n_pre  = LenW'(1);
            end
            mode_d   = ModePlain;
            acc_d    = '0;
            cnt_d    = '0;
            do_plain = 1'b1;
          end
        end
        ModeUni: begin
          if (hex_ok) begin
            dig_we = 1'b1;
            acc_d  = acc_uni;
            cnt_d  = cnt_inc;
            if (cnt_inc >= (long_q ? 4'd8 : 4'd4)) begin
              pre    = uni_seq.bytes;
              n_pre  = uni_seq.len;
              mode_d = ModePlain;
              acc_d  = '0;
              cnt_d  = '0;
              long_d = 1'b0;
            end
          end else begin
            pre      = lit;
            n_pre    = lit_len;
            mode_d   = ModePlain;
            acc_d    = '0;
            cnt_d    = '0;
            long_d   = 1'b0;
            do_plain = 1'b1;
          end
        end
        default: ;
      endcase

      if (do_plain) begin
        if (en_q && c == CharBslash) begin
          mode_d = ModeEsc;
        end else begin
          tail = 1'b1;
        end
      end
    end else begin
      case (mode_q)
        ModeEsc: begin
          pre[0] = CharBslash;
          n_pre  = LenW'(1);
        end
        ModeOct: begin
          pre[0] = acc_q[7:0];
          n_pre  = LenW'(1);
        end
        ModeHex: begin
          if (cnt_q == 4'd0) begin
            pre[0] = CharBslash;
            pre[1] = CharX;
            n_pre  = LenW'(2);
          end else begin
            pre[0] = acc_q[7:0];
            n_pre  = LenW'(1);
          end
        end
        ModeUni: begin
          pre   = lit;
          n_pre = lit_len;
        end
        ModeStop: stopped = 1'b1;
        default: ;
      endcase
      mode_d = ModePlain;
      acc_d  = '0;
      cnt_d  = '0;
      long_d = 1'b0;
      // nothing flushed: a single empty beat still carries the end flag
      if (n_pre == '0) begin
        pre[0]   = 8'h00;
        n_pre    = LenW'(1);
        has_byte = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MaxBeats; i++) begin
      q_cmd_o.bytes[i] = (LenW'(i) < n_pre) ? pre[i] : c;
    end
    q_cmd_o.len      = n_pre + LenW'(tail);
    q_cmd_o.has_byte = has_byte;
    q_cmd_o.done     = end_marker_i;
    q_cmd_o.stopped  = stopped;
  end

  assign q_push_o = accept && (q_cmd_o.len != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePlain;
      acc_q  <= '0;
      cnt_q  <= '0;
      long_q <= 1'b0;
      en_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (accept) begin
        mode_q <= mode_d;
        acc_q  <= acc_d;
        cnt_q  <= cnt_d;
        long_q <= long_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && dig_we) begin
      dig_q[cnt_q[2:0]] <= c;
    end
  end

endmodule

>>> hdl/esi_fifo.sv
// Short command queue between the front end and the emitter.
module esi_fifo import esi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_next(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_next(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

>>> hdl/esi_back.sv
// Emitter: walks a queued byte list and drives one registered output beat per cycle while out_ready_i allows.
module esi_back import esi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_out_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       text_done_o,
  output logic       stop_seen_o
);

  logic [IdxW-1:0] idx_q;
  logic            out_valid_q;
  logic [7:0]      byte_q;
  logic            bv_q, last_q, done_q, stop_q;
  logic            load;
  logic            last;

  assign load    = q_valid_i && (!out_valid_q || out_ready_i);
  assign last    = (LenW'(idx_q) + LenW'(1)) == q_cmd_i.len;
  assign q_pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? '0 : idx_q + IdxW'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= q_cmd_i.bytes[idx_q];
      bv_q   <= q_cmd_i.has_byte;
      last_q <= last;
      done_q <= q_cmd_i.done && last;
      stop_q <= q_cmd_i.stopped && last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_out_o   = byte_q;
  assign byte_valid_o = bv_q;
  assign run_last_o   = last_q;
  assign text_done_o  = done_q;
  assign stop_seen_o  = stop_q;

endmodule

>>> hdl/escape_sequence_interpreter.sv
// Top level of the backslash escape interpreter.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  config   | cfg_we_i                   | cfg_wdata_i (escapes enabled)
//  input    | in_valid_i / in_ready_o    | char_in_i, end_marker_i
//  output   | out_valid_o / out_ready_i  | byte_out_o, byte_valid_o, run_last_o,
//           |                            | text_done_o, stop_seen_o
//
// An input beat is taken whenever the 2-entry command queue has room.
// The emitter sends one output beat per cycle while out_ready_i allows; an item
// causes up to 10 beats, and an item with no beat is not queued. From input to
// output a byte passes through the queue entry and the output register.
// rst_ni clears the parser state, the queue and the output register at once.
// Either side may stall freely; the queue absorbs short output bursts.
module escape_sequence_interpreter import esi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       end_marker_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_out_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       text_done_o,
  output logic       stop_seen_o
);

  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  esi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_in_i    (char_in_i),
    .end_marker_i (end_marker_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  esi_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  esi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (head_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte_out_o   (byte_out_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .text_done_o  (text_done_o),
    .stop_seen_o  (stop_seen_o)
  );

endmodule

>>> dv/tb.sv
// Testbench for escape_sequence_interpreter: directed and random text against a predictor.
`timescale 1ns / 100ps

module tb;
  import esi_pkg::MaxBeats;

  localparam int unsigned IdlePct      = 38;
  localparam int unsigned RandomItems  = 250;
  localparam int unsigned SteadyItems  = 80;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned StallLimit   = 4000;

  // Characters the decoder treats specially.
  localparam logic [7:0] CH_BACKSLASH  = "\\";
  localparam logic [7:0] CH_ZERO       = "0";
  localparam logic [7:0] CH_SEVEN      = "7";
  localparam logic [7:0] CH_NINE       = "9";
  localparam logic [7:0] CH_LOWER_A    = "a";
  localparam logic [7:0] CH_LOWER_F    = "f";
  localparam logic [7:0] CH_UPPER_A    = "A";
  localparam logic [7:0] CH_UPPER_F    = "F";

  // Letters that follow a backslash.
  localparam logic [7:0] ESC_BELL      = "a";
  localparam logic [7:0] ESC_BACKSPACE = "b";
  localparam logic [7:0] ESC_STOP      = "c";
  localparam logic [7:0] ESC_ESCAPE    = "e";
  localparam logic [7:0] ESC_ESCAPE_UP = "E";
  localparam logic [7:0] ESC_FORMFEED  = "f";
  localparam logic [7:0] ESC_NEWLINE   = "n";
  localparam logic [7:0] ESC_RETURN    = "r";
  localparam logic [7:0] ESC_TAB       = "t";
  localparam logic [7:0] ESC_VTAB      = "v";
  localparam logic [7:0] ESC_OCTAL     = "0";
  localparam logic [7:0] ESC_HEX       = "x";
  localparam logic [7:0] ESC_UNI_SHORT = "u";
  localparam logic [7:0] ESC_UNI_LONG  = "U";

  // Bytes the simple escapes produce.
  localparam logic [7:0] BYTE_BEL = 8'h07;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_VT  = 8'h0B;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_ESC = 8'h1B;

  localparam logic [31:0] CP_MAX  = 32'h10FFFF;
  localparam logic [31:0] SURR_LO = 32'hD800;
  localparam logic [31:0] SURR_HI = 32'hDFFF;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  typedef enum logic [2:0] {
    PARSE_PLAIN, PARSE_ESC, PARSE_OCT, PARSE_HEX, PARSE_UNI, PARSE_STOP
  } parse_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
    logic       done;
    logic       stop;
  } beat_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       cfg_we_i     = 1'b0;
  logic       cfg_wdata_i  = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [7:0] char_in_i    = 8'h00;
  logic       end_marker_i = 1'b0;
  logic       out_ready_i  = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] byte_out_o;
  logic       byte_valid_o;
  logic       run_last_o;
  logic       text_done_o;
  logic       stop_seen_o;

  escape_sequence_interpreter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_in_i    (char_in_i),
    .end_marker_i (end_marker_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte_out_o   (byte_out_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .text_done_o  (text_done_o),
    .stop_seen_o  (stop_seen_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decoder shadow state
  logic        escapes_on;
  parse_mode_e mode_q;
  logic [31:0] acc_q;
  logic [3:0]  cnt_q;
  logic [7:0]  digits_q [8];
  logic        long_q;

  beat_t       item_beats [$];
  beat_t       expected_beats [$];
  int unsigned items_counted;
  int unsigned errors;
  int unsigned quiet_cycles;
  bit          steady;

  function automatic int hex_val(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic void emit(input logic [7:0] b);
    beat_t one;
    one = '0;
    one.data = b;
    one.has_byte = 1'b1;
    if (item_beats.size() < MaxBeats) item_beats.push_back(one);
  endfunction

  function automatic void clear_escape();
    mode_q = PARSE_PLAIN;
    acc_q  = '0;
    cnt_q  = '0;
    long_q = 1'b0;
  endfunction

  function automatic void emit_uni_literal();
    emit(CH_BACKSLASH);
    emit(long_q ? ESC_UNI_LONG : ESC_UNI_SHORT);
    for (int i = 0; i < cnt_q && i < 8; i++) emit(digits_q[i]);
  endfunction

  function automatic void emit_codepoint(input logic [31:0] cp);
    if (cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
      emit_uni_literal();
    end else if (cp <= 32'h7F) begin
      emit(cp[7:0]);
    end else if (cp <= 32'h7FF) begin
      emit(UTF8_LEAD2 | 8'(cp[10:6]));
      emit(UTF8_CONT | 8'(cp[5:0]));
    end else if (cp <= 32'hFFFF) begin
      emit(UTF8_LEAD3 | 8'(cp[15:12]));
      emit(UTF8_CONT | 8'(cp[11:6]));
      emit(UTF8_CONT | 8'(cp[5:0]));
    end else begin
      emit(UTF8_LEAD4 | 8'(cp[20:18]));
      emit(UTF8_CONT | 8'(cp[17:12]));
      emit(UTF8_CONT | 8'(cp[11:6]));
      emit(UTF8_CONT | 8'(cp[5:0]));
    end
  endfunction

  function automatic void plain_char(input logic [7:0] c);
    if (!escapes_on || c != CH_BACKSLASH) emit(c);
    else mode_q = PARSE_ESC;
  endfunction

  function automatic void escape_char(input logic [7:0] c);
    clear_escape();
    case (c)
      CH_BACKSLASH:  emit(CH_BACKSLASH);
      ESC_BELL:      emit(BYTE_BEL);
      ESC_BACKSPACE: emit(BYTE_BS);
      ESC_STOP:      mode_q = PARSE_STOP;
      ESC_ESCAPE, ESC_ESCAPE_UP: emit(BYTE_ESC);
      ESC_FORMFEED:  emit(BYTE_FF);
      ESC_NEWLINE:   emit(BYTE_LF);
      ESC_RETURN:    emit(BYTE_CR);
      ESC_TAB:       emit(BYTE_TAB);
      ESC_VTAB:      emit(BYTE_VT);
      ESC_OCTAL:     mode_q = PARSE_OCT;
      ESC_HEX:       mode_q = PARSE_HEX;
      ESC_UNI_SHORT: mode_q = PARSE_UNI;
      ESC_UNI_LONG: begin
        mode_q = PARSE_UNI;
        long_q = 1'b1;
      end
      default: begin
        emit(CH_BACKSLASH);
        emit(c);
      end
    endcase
  endfunction

  function automatic void decode_char(input logic [7:0] c);
    int h;
    int unsigned need;
    h = hex_val(c);
    case (mode_q)
      PARSE_PLAIN: plain_char(c);
      PARSE_ESC:   escape_char(c);
      PARSE_OCT: begin
        if (c >= CH_ZERO && c <= CH_SEVEN) begin
          acc_q = ((acc_q << 3) | 32'(c - CH_ZERO)) & 32'hFF;
          cnt_q++;
          if (cnt_q >= 3) begin
            emit(acc_q[7:0]);
            clear_escape();
          end
        end else begin
          emit(acc_q[7:0]);
          clear_escape();
          plain_char(c);
        end
      end
      PARSE_HEX: begin
        if (h >= 0) begin
          acc_q = ((acc_q << 4) | 32'(h)) & 32'hFF;
          cnt_q++;
          if (cnt_q >= 2) begin
            emit(acc_q[7:0]);
            clear_escape();
          end
        end else begin
          if (cnt_q == 0) begin
            emit(CH_BACKSLASH);
            emit(ESC_HEX);
          end else begin
            emit(acc_q[7:0]);
          end
          clear_escape();
          plain_char(c);
        end
      end
      PARSE_UNI: begin
        need = long_q ? 8 : 4;
        if (h >= 0) begin
          digits_q[cnt_q[2:0]] = c;
          acc_q = (acc_q << 4) | 32'(h);
          cnt_q++;
          if (cnt_q >= need) begin
            emit_codepoint(acc_q);
            clear_escape();
          end
        end else begin
          emit_uni_literal();
          clear_escape();
          plain_char(c);
        end
      end
      default: ;  // after \c everything is dropped until the end marker
    endcase
  endfunction

  // Works out the beats one accepted item causes and queues them.
  function automatic void predict_item(input logic [7:0] c, input logic is_end);
    logic  stopped;
    beat_t tail;
    stopped = 1'b0;
    item_beats.delete();
    if (!is_end) begin
      decode_char(c);
    end else begin
      case (mode_q)
        PARSE_ESC: emit(CH_BACKSLASH);
        PARSE_OCT: emit(acc_q[7:0]);
        PARSE_HEX: begin
          if (cnt_q == 0) begin
            emit(CH_BACKSLASH);
            emit(ESC_HEX);
          end else begin
            emit(acc_q[7:0]);
          end
        end
        PARSE_UNI:  emit_uni_literal();
        PARSE_STOP: stopped = 1'b1;
        default: ;
      endcase
      clear_escape();
      foreach (digits_q[i]) digits_q[i] = 8'h00;
      if (item_beats.size() == 0) item_beats.push_back('0);
    end
    if (item_beats.size() != 0) begin
      tail = item_beats.pop_back();
      tail.last = 1'b1;
      tail.done = is_end;
      tail.stop = stopped;
      item_beats.push_back(tail);
    end
    foreach (item_beats[i]) expected_beats.push_back(item_beats[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: mismatch on %s: expected %02h, got %02h", $time, what, want, got);
    errors++;
  endtask

  task automatic compare_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) report_mismatch(what, want, got);
  endtask

  // Output beat checker
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", 8'h00, byte_out_o);
      end else begin
        want = expected_beats.pop_front();
        compare_field("byte_out", want.data, byte_out_o);
        compare_field("byte_valid", 8'(want.has_byte), 8'(byte_valid_o));
        compare_field("run_last", 8'(want.last), 8'(run_last_o));
        compare_field("text_done", 8'(want.done), 8'(text_done_o));
        compare_field("stop_seen", 8'(want.stop), 8'(stop_seen_o));
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Valid is left high after acceptance; the next call either lowers it or
  // replaces the payload at the following falling edge.
  task automatic send_item(input logic [7:0] c, input logic is_end);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    char_in_i    <= c;
    end_marker_i <= is_end;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (mode_q != PARSE_STOP || is_end) items_counted++;
    predict_item(c, is_end);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    // a backslash or digit causes no beat but may still be in flight
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_escapes(input logic enable);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enable;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    escapes_on  = enable;
  endtask

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    if (nib < 10) return CH_ZERO + nib;
    return 8'(($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + nib - 10);
  endfunction

  function automatic logic [7:0] simple_escape(input int unsigned idx);
    case (idx)
      0: return CH_BACKSLASH;
      1: return ESC_BELL;
      2: return ESC_BACKSPACE;
      3: return ESC_ESCAPE;
      4: return ESC_ESCAPE_UP;
      5: return ESC_FORMFEED;
      6: return ESC_NEWLINE;
      7: return ESC_RETURN;
      8: return ESC_TAB;
      default: return ESC_VTAB;
    endcase
  endfunction

  task automatic send_unicode(input logic long_form);
    int unsigned ndig, keep;
    logic [31:0] cp;
    logic [7:0]  stopper;
    ndig = long_form ? 8 : 4;
    case ($urandom_range(0, long_form ? 5 : 3))
      0: cp = $urandom_range(0, 32'h7F);
      1: cp = $urandom_range(32'h80, 32'h7FF);
      2: cp = $urandom_range(32'h800, 32'hFFFF);
      3: cp = $urandom_range(SURR_LO, SURR_HI);
      4: cp = $urandom_range(32'h10000, CP_MAX);
      default: cp = $urandom_range(CP_MAX + 1, 32'hFFFF_FFFF);
    endcase
    keep = ($urandom_range(0, 4) == 0) ? $urandom_range(0, ndig - 1) : ndig;
    send_item(long_form ? ESC_UNI_LONG : ESC_UNI_SHORT, 1'b0);
    for (int i = 0; i < keep; i++) send_item(nibble_char(cp[(ndig - 1 - i) * 4 +: 4]), 1'b0);
    if (keep < ndig) begin
      do stopper = 8'($urandom_range(0, 255)); while (hex_val(stopper) >= 0);
      if ($urandom_range(0, 3) == 0) send_end();
      else send_item(stopper, 1'b0);
    end
  endtask

  task automatic send_random_escape();
    int unsigned kind;
    kind = $urandom_range(0, 7);
    send_item(CH_BACKSLASH, 1'b0);
    case (kind)
      0: send_item(simple_escape($urandom_range(0, 9)), 1'b0);
      1: begin
        send_item(ESC_OCTAL, 1'b0);
        repeat ($urandom_range(0, 3)) send_item(8'(CH_ZERO + $urandom_range(0, 7)), 1'b0);
      end
      2: begin
        send_item(ESC_HEX, 1'b0);
        repeat ($urandom_range(0, 2)) send_item(nibble_char(4'($urandom_range(0, 15))), 1'b0);
      end
      3: send_unicode(1'b0);
      4: send_unicode(1'b1);
      5: send_item(8'($urandom_range(0, 255)), 1'b0);
      6: ;  // lone backslash, the next item finishes it
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(ESC_STOP, 1'b0);
          repeat ($urandom_range(0, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
          send_end();
        end else begin
          send_item(simple_escape($urandom_range(0, 9)), 1'b0);
        end
      end
    endcase
  endtask

  task automatic test_passthrough();
    set_escapes(1'b0);
    send_text("\\n");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_end();
    send_end();
  endtask

  task automatic test_simple_escapes();
    set_escapes(1'b1);
    send_text("\\\\\\a\\b\\e\\E\\f\\n\\r\\t\\v\\q");
    send_item(CH_BACKSLASH, 1'b0);
    send_item(8'hFF, 1'b0);
    send_end();
  endtask

  task automatic test_numeric_escapes();
    // full octal truncated to a byte, short octal, empty and short hex
    send_text("\\0777\\07q\\xg\\xfF\\x5\\");
    send_end();
    send_text("\\0");
    send_end();
    send_text("\\x");
    send_end();
  endtask

  task automatic test_unicode_escapes();
    // top code point, one past it, a surrogate, a short long form, plain ASCII
    send_text("\\U0010FFFF\\U00110000\\udFfF\\U1234567z\\u0041");
    send_text("\\U0011");
    send_end();
  endtask

  task automatic test_stop_escape();
    send_text("\\cab\\n");
    send_end();
    send_end();
  endtask

  task automatic test_random_text();
    int unsigned target, roll;
    target = items_counted + RandomItems;
    set_escapes(1'b1);
    while (items_counted < target) begin
      steady = (target - items_counted > RandomItems - SteadyItems);
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_end();
        if ($urandom_range(0, 3) == 0) set_escapes($urandom_range(0, 99) < 75);
      end else if (roll < 40) begin
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_random_escape();
      end
    end
    steady = 1'b0;
    send_end();
  endtask

  initial begin
    escapes_on    = 1'b0;
    items_counted = 0;
    errors        = 0;
    quiet_cycles  = 0;
    steady        = 1'b0;
    clear_escape();
    foreach (digits_q[i]) digits_q[i] = 8'h00;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_passthrough();
    test_simple_escapes();
    test_numeric_escapes();
    test_unicode_escapes();
    test_stop_escape();
    test_random_text();

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
